[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the frame header parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WSF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define WSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/wsfhp_pkg.sv]
// ----------------------------------------------------------------------------
// wsfhp_pkg
// Types and constants shared by the frame header parser modules.
// ----------------------------------------------------------------------------
package wsfhp_pkg;

   // Parser phase within one frame header.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_EXT16 = 2'd2,
      PH_EXT64 = 2'd3
   } phase_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RESERVED  = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   // One received byte with its flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       buffer_end;
   } beat_type;

   // One parse result.
   typedef struct packed {
      logic [3:0]  opcode;
      logic        masked;
      logic [63:0] body_len;
      logic [3:0]  hdr_bytes;
      status_type  status;
   } result_type;

   localparam logic [7:0] RSV_MASK    = 8'h70;
   localparam logic [6:0] LEN7_EXT16  = 7'd126;
   localparam logic [6:0] LEN7_EXT64  = 7'd127;
   localparam logic [3:0] HDR_SHORT   = 4'd2;
   localparam logic [3:0] HDR_EXT16   = 4'd4;
   localparam logic [3:0] HDR_EXT64   = 4'd10;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

[hdl/wsfhp_in_stage.sv]
// ----------------------------------------------------------------------------
// wsfhp_in_stage
// Input register: captures one byte beat and holds it until the parser
// consumes it. A new beat is taken in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module wsfhp_in_stage
   import wsfhp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  beat_type req_beat,
   input  logic     advance,
   output logic     beat_valid,
   output beat_type beat
);

   logic     valid_ff, valid_in;
   beat_type beat_ff;
   logic     accept;

   // Room exists when empty or when the held beat moves on this cycle.
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Beat payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

[hdl/wsfhp_parser.sv]
// ----------------------------------------------------------------------------
// wsfhp_parser
// Header parse state, single-pass next-state logic and the result register.
// Each consumed beat updates the state; a finished or failed header loads
// the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfhp_parser
   import wsfhp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_valid,
   input  beat_type   beat,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  left_ff, left_in;
   logic        out_valid_ff, out_valid_in;
   result_type  result_ff;

   logic        res_fire;
   result_type  res;
   logic [6:0]  len7;
   logic [63:0] acc_shift;
   logic [3:0]  left_dec;

   logic        len_state_clear;
   logic        in_ext;
   logic        ok_shape;
   logic        err_shape;
   logic        result_load;
   logic        idle_with_result;

   // A beat is consumed when the result register is free or being drained.
   assign advance = beat_valid && (!out_valid_ff || rsp_ready);

   assign len7      = beat.data_byte[6:0];
   assign acc_shift = {acc_ff[55:0], beat.data_byte};
   assign left_dec  = left_ff - 4'd1;

   // Next parse state and result for the beat in the input register.
   always_comb begin
      phase_in = phase_ff;
      opcode_in = opcode_ff;
      mask_in = mask_ff;
      acc_in = acc_ff;
      left_in = left_ff;
      res_fire = 1'b0;
      res = '0;
      res.status = ST_OK;

      if (beat.frame_start) begin
         // A start byte abandons any header in progress.
         phase_in = PH_IDLE;
         opcode_in = '0;
         mask_in = 1'b0;
         acc_in = '0;
         left_in = '0;
         if (beat.buffer_end) begin
            res_fire = 1'b1;
            res.status = ST_TRUNCATED;
         end else if ((beat.data_byte & RSV_MASK) != 8'h00) begin
            res_fire = 1'b1;
            res.status = ST_RESERVED;
         end else begin
            opcode_in = beat.data_byte[3:0];
            phase_in = PH_LEN;
         end
      end else begin
         case (phase_ff)
            PH_LEN: begin
               if (len7 < LEN7_EXT16) begin
                  res_fire = 1'b1;
                  res.opcode = opcode_ff;
                  res.masked = beat.data_byte[7];
                  res.body_len = {57'd0, len7};
                  res.hdr_bytes = HDR_SHORT;
               end else if (beat.buffer_end) begin
                  res_fire = 1'b1;
                  res.status = ST_TRUNCATED;
               end else begin
                  mask_in = beat.data_byte[7];
                  acc_in = '0;
                  if (len7 == LEN7_EXT16) begin
                     phase_in = PH_EXT16;
                     left_in = EXT16_BYTES;
                  end else begin
                     phase_in = PH_EXT64;
                     left_in = EXT64_BYTES;
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               if (left_dec == 4'd0) begin
                  res_fire = 1'b1;
                  res.opcode = opcode_ff;
                  res.masked = mask_ff;
                  res.body_len = acc_shift;
                  res.hdr_bytes = (phase_ff == PH_EXT16) ? HDR_EXT16 : HDR_EXT64;
               end else if (beat.buffer_end) begin
                  res_fire = 1'b1;
                  res.status = ST_TRUNCATED;
               end else begin
                  acc_in = acc_shift;
                  left_in = left_dec;
               end
            end
            default: begin
               // Idle bytes without a start flag are dropped.
               phase_in = PH_IDLE;
            end
         endcase
         // Any result returns the parser to idle.
         if (res_fire) begin
            phase_in = PH_IDLE;
            opcode_in = '0;
            mask_in = 1'b0;
            acc_in = '0;
            left_in = '0;
         end
      end
   end

   // Parse state registers, updated only on a consumed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         opcode_ff <= '0;
         mask_ff <= 1'b0;
         acc_ff <= '0;
         left_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff <= mask_in;
         acc_ff <= acc_in;
         left_ff <= left_in;
      end
   end

   // Result valid flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_fire;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance && res_fire) begin
         result_ff <= res;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

   // Conditions watched by the checks below.
   assign len_state_clear  = (left_ff == 4'd0) && (acc_ff == 64'd0);
   assign in_ext           = (phase_ff == PH_EXT16) || (phase_ff == PH_EXT64);
   assign ok_shape         = (rsp_result.status != ST_OK) ||
                             (rsp_result.hdr_bytes == HDR_SHORT) ||
                             (rsp_result.hdr_bytes == HDR_EXT16) ||
                             (rsp_result.hdr_bytes == HDR_EXT64);
   assign err_shape        = (rsp_result.status == ST_OK) ||
                             ((rsp_result.hdr_bytes == 4'd0) &&
                              (rsp_result.body_len == 64'd0));
   assign result_load      = advance && res_fire;
   assign idle_with_result = (phase_ff == PH_IDLE) && rsp_valid;

   `WSF_ASSERT_ALWAYS(a_idle_clean, (phase_ff != PH_IDLE) || len_state_clear, "stale idle state")
   `WSF_ASSERT_ALWAYS(a_left_in_ext, in_ext || (left_ff == 4'd0), "count outside extension")
   `WSF_ASSERT_ALWAYS(a_ok_hdr_len, !rsp_valid || ok_shape, "bad ok header size")
   `WSF_ASSERT_ALWAYS(a_err_zero, !rsp_valid || err_shape, "error fields not zero")
   `WSF_ASSERT_NEXT(a_result_idle, result_load, idle_with_result, "not idle after a result")

endmodule

[hdl/websocket_frame_header_parser.sv]
// A byte waits in the input register; a result loads when its last header byte is consumed.
// Throughput: one byte per cycle while results drain; a result held by a low rsp_tready
// stalls the input until it is taken.
// The input register and the result register set this timing; the parse step
// between them is a single pass of shifts and compares.
// Reset: synchronous, active high; clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
// websocket_frame_header_parser
// Parses frame headers from a byte stream: opcode, mask flag, 7/16/64-bit
// payload length, header size and status.
// ----------------------------------------------------------------------------
module websocket_frame_header_parser
   import wsfhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [3:0] opcode, [4] masked, [68:5] body_len,
                                    // [72:69] hdr_bytes, [79:73] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   beat_type   req_beat;
   beat_type   beat;
   logic       beat_valid;
   logic       advance;
   result_type result;

   assign req_beat.data_byte   = req_tdata;
   assign req_beat.frame_start = req_tuser;
   assign req_beat.buffer_end  = req_tlast;

   // Input register.
   wsfhp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_beat   (req_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   // Parse logic and result register.
   wsfhp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the result beat.
   assign rsp_tdata = {7'd0, result.hdr_bytes, result.body_len,
                       result.masked, result.opcode};
   assign rsp_tuser = result.status;

endmodule
